// File: hdl/ultrasonic_echo_ranger_defines.svh
// Assertion macros used by the ultrasonic echo ranger core.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UER_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ultrasonic echo ranger: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ultrasonic echo ranger: next-cycle check failed");

`endif

// File: hdl/uer_pkg.sv
// Package with the types, codes and constants of the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRELOW   = 3'd1,
        PH_TRIGHIGH = 3'd2,
        PH_WAITRISE = 3'd3,
        PH_MEASURE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2,
        ST_DISC  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_INTERVAL    = 2'd0,
        REG_MAX_TIMEOUT = 2'd1,
        REG_ARM_TIMEOUT = 2'd2,
        REG_MIN_WIDTH   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [31:0] interval_ticks;
        logic [15:0] max_timeout_ticks;
        logic [15:0] arm_timeout_ticks;
        logic [15:0] min_width_ticks;
    } uer_cfg_t;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W = 16;
    localparam int DIST_W = 12;

    localparam logic [31:0] INTERVAL_RESET = 32'd3600000000;
    localparam logic [15:0] MAX_TIMEOUT_RESET = 16'd26100;
    localparam logic [15:0] ARM_TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] MIN_WIDTH_RESET = 16'd100;

    localparam logic [15:0] PRE_LOW_TICKS = 16'd2;
    localparam logic [15:0] TRIG_HIGH_TICKS = 16'd10;

    // Division by 58 as a reciprocal multiply: exact for all 16-bit widths.
    localparam int US_PER_CM = 58;
    localparam int DIV_SHIFT = 21;
    localparam logic [31:0] DIV_MULT = 32'(((1 << DIV_SHIFT) + US_PER_CM - 1) / US_PER_CM);

    localparam logic signed [11:0] DIST_BUSY = -12'sd1;
    localparam logic signed [11:0] DIST_RANGE = -12'sd2;
    localparam logic signed [11:0] DIST_DISC = -12'sd3;

endpackage

// File: hdl/uer_cfg_regs.sv
// Configuration register bank of the ultrasonic echo ranger.
`timescale 1ns / 1ps

module uer_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output uer_pkg::uer_cfg_t              cfg
);
    import uer_pkg::*;

    uer_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ticks    <= INTERVAL_RESET;
            cfg_reg.max_timeout_ticks <= MAX_TIMEOUT_RESET;
            cfg_reg.arm_timeout_ticks <= ARM_TIMEOUT_RESET;
            cfg_reg.min_width_ticks   <= MIN_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_INTERVAL:    cfg_reg.interval_ticks    <= cfg_data;
                REG_MAX_TIMEOUT: cfg_reg.max_timeout_ticks <= cfg_data[15:0];
                REG_ARM_TIMEOUT: cfg_reg.arm_timeout_ticks <= cfg_data[15:0];
                REG_MIN_WIDTH:   cfg_reg.min_width_ticks   <= cfg_data[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/uer_core.sv
// Input register, phase sequencer and result register of the echo ranger.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module uer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uer_pkg::uer_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          echo_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          trigger_level,
    output logic                          done_res,
    output logic [1:0]                    status,
    output logic signed [uer_pkg::DIST_W-1:0] distance_cm
);
    import uer_pkg::*;

    logic s1_valid_reg;
    logic echo_reg;
    logic advance;

    phase_t phase_reg, phase_next;
    logic [COUNT_W-1:0] phase_count_reg, phase_count_next;
    logic [31:0] interval_count_reg, interval_count_next;

    logic out_valid_reg;
    logic trigger_reg, trigger_next;
    logic done_reg, done_next;
    status_t status_reg, status_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;

    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] arm_limit;
    logic [31:0] div_prod;
    logic signed [DIST_W-1:0] dist_ok;

    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            echo_reg <= echo_level;
        end
    end

    assign count_inc = phase_count_reg + 16'd1;
    assign arm_limit = (cfg.arm_timeout_ticks == 16'd0) ? 16'd1 : cfg.arm_timeout_ticks;
    assign div_prod = 32'(phase_count_reg) * DIV_MULT;
    assign dist_ok = DIST_W'(div_prod[31:DIV_SHIFT]);

    always_comb
    begin
        phase_next = phase_reg;
        phase_count_next = phase_count_reg;
        interval_count_next = (interval_count_reg == 32'hFFFF_FFFF) ?
                              interval_count_reg : interval_count_reg + 32'd1;
        trigger_next = 1'b0;
        done_next = 1'b0;
        status_next = ST_OK;
        dist_next = '0;

        unique case (phase_reg)
            PH_PRELOW:
            begin
                phase_count_next = count_inc;
                if (count_inc >= PRE_LOW_TICKS)
                begin
                    phase_next = PH_TRIGHIGH;
                    phase_count_next = '0;
                end
            end
            PH_TRIGHIGH:
            begin
                trigger_next = 1'b1;
                phase_count_next = count_inc;
                if (count_inc >= TRIG_HIGH_TICKS)
                begin
                    phase_next = PH_WAITRISE;
                    phase_count_next = '0;
                end
            end
            PH_WAITRISE:
            begin
                if (echo_reg)
                begin
                    phase_next = PH_MEASURE;
                    phase_count_next = 16'd1;
                    if (cfg.max_timeout_ticks <= 16'd1)
                    begin
                        phase_next = PH_IDLE;
                        phase_count_next = '0;
                        done_next = 1'b1;
                        status_next = ST_RANGE;
                        dist_next = DIST_RANGE;
                    end
                end
                else
                begin
                    phase_count_next = count_inc;
                    if (count_inc >= arm_limit)
                    begin
                        phase_next = PH_IDLE;
                        phase_count_next = '0;
                        done_next = 1'b1;
                        status_next = ST_DISC;
                        dist_next = DIST_DISC;
                    end
                end
            end
            PH_MEASURE:
            begin
                phase_next = PH_IDLE;
                phase_count_next = '0;
                done_next = 1'b1;
                if (echo_reg)
                begin
                    if (count_inc >= cfg.max_timeout_ticks)
                    begin
                        status_next = ST_RANGE;
                        dist_next = DIST_RANGE;
                    end
                    else
                    begin
                        phase_next = PH_MEASURE;
                        phase_count_next = count_inc;
                        done_next = 1'b0;
                    end
                end
                else if (phase_count_reg < cfg.min_width_ticks)
                begin
                    status_next = ST_DISC;
                    dist_next = DIST_DISC;
                end
                else
                begin
                    status_next = ST_OK;
                    dist_next = dist_ok;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                phase_count_next = '0;
                if (interval_count_next >= cfg.interval_ticks)
                begin
                    interval_count_next = '0;
                    if (echo_reg)
                    begin
                        done_next = 1'b1;
                        status_next = ST_BUSY;
                        dist_next = DIST_BUSY;
                    end
                    else
                    begin
                        phase_next = PH_PRELOW;
                        phase_count_next = 16'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            phase_count_reg <= '0;
            interval_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                phase_count_reg <= phase_count_next;
                interval_count_reg <= interval_count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            trigger_reg <= trigger_next;
            done_reg <= done_next;
            status_reg <= status_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign trigger_level = trigger_reg;
    assign done_res = done_reg;
    assign status = status_reg;
    assign distance_cm = dist_reg;

    `UER_ASSERT_IMP(a_done_trigger_low, out_valid_reg && done_reg, !trigger_reg)
    `UER_ASSERT_IMP(a_idle_result_zero, out_valid_reg && !done_reg,
                    status_reg == ST_OK && dist_reg == '0)
    `UER_ASSERT_IMP(a_trig_count_bound, phase_reg == PH_TRIGHIGH,
                    phase_count_reg < TRIG_HIGH_TICKS)
    `UER_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !advance,
                     s1_valid_reg && $stable(echo_reg))

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration bank and ranging core.
`timescale 1ns / 1ps

// Each accepted item is one microsecond tick with the sampled echo level, and
// each gives exactly one result item: the trigger drive level for that tick,
// a done flag, and on done a status with a distance in cm (width/58) or a
// negative error code. One item can be accepted in every clock cycle while
// results are taken. An accepted item waits in the input register until the
// result register is free; its result then passes the single-pass phase
// sequencer into the result register. Configuration registers are written
// through cfg_we, cfg_index and cfg_data.
module ultrasonic_echo_ranger (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              echo_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              trigger_level,
    output logic                              done_res,
    output logic [1:0]                        status,
    output logic signed [uer_pkg::DIST_W-1:0] distance_cm
);
    import uer_pkg::*;

    uer_cfg_t cfg;

    uer_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trigger_level (trigger_level),
        .done_res      (done_res),
        .status        (status),
        .distance_cm   (distance_cm)
    );

endmodule
